// ===== sv/assert_macros.svh =====
// Assertion helpers for the rotator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge, ignored while reset is high.
`define QVR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define QVR_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared constants and codes of the quaternion vector rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

  localparam int VEC_WIDTH_DEF      = 24;
  localparam int QUAT_FRAC_BITS_DEF = 15;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;

  // Register index, taken from the word address.
  typedef enum logic [2:0] {
    REG_QUAT_W        = 3'd0,
    REG_QUAT_X        = 3'd1,
    REG_QUAT_Y        = 3'd2,
    REG_QUAT_Z        = 3'd3,
    REG_MATRIX_SOURCE = 3'd4
  } reg_idx_t;

  // Matrix source; the spare code falls back to identity.
  typedef enum logic [1:0] {
    SRC_IDENTITY = 2'd0,
    SRC_I2O      = 2'd1,
    SRC_O2I      = 2'd2
  } mat_src_t;

endpackage

`default_nettype wire

// ===== sv/quaternion_vector_rotator.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotator
// Rotates streaming 3D vectors by a matrix built from a configured quaternion.
// ----------------------------------------------------------------------------
// The block takes one vector beat per clock while the output is not stalled
// and returns one rotated vector beat per input, in order. A beat accepted
// passes through five register stages (capture, alignment, products, row
// sums, output) on its way to the output. The rate is set by the product
// stage: nine coefficient by component multipliers, one per matrix entry,
// each used once per beat. The rotation matrix is rebuilt from the APB
// registers by its own two-stage pipeline (nine quaternion products, then
// the entry sums); an alignment stage in the vector path lets a beat
// accepted right after a register write see the new matrix. Registers may
// only be written while no beat is in flight. A stall on the result side,
// while a result waits there, holds the whole vector pipeline and is passed
// straight back as a stall on the input side; the output register keeps the
// result until it is taken. Components are signed fixed point; matrix
// entries are Q4.QUAT_FRAC_BITS; each output is floored, clamped to
// VEC_WIDTH bits, and the saturated flag marks any clamped component.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module quaternion_vector_rotator #(
  parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // APB register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [qvr_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [qvr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [qvr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  // vector input channel
  input  wire logic                              vec_valid,
  output logic                                   vec_stall,
  input  wire logic signed [VEC_WIDTH-1:0]       vec_x,
  input  wire logic signed [VEC_WIDTH-1:0]       vec_y,
  input  wire logic signed [VEC_WIDTH-1:0]       vec_z,
  input  wire logic                              direction,
  // result channel
  output logic                                   res_valid,
  input  wire logic                              res_stall,
  output logic signed [VEC_WIDTH-1:0]            out_x,
  output logic signed [VEC_WIDTH-1:0]            out_y,
  output logic signed [VEC_WIDTH-1:0]            out_z,
  output logic                                   saturated
);

  import qvr_pkg::*;

  // Widths: quaternion component, product, raw entry (Q.2Q with headroom),
  // entry after the shift, entry*component product, row sum.
  localparam int QW  = QUAT_FRAC_BITS + 1;
  localparam int PW  = 2 * QW;
  localparam int RW  = 2 * QUAT_FRAC_BITS + 4;
  localparam int MW  = QUAT_FRAC_BITS + 4;
  localparam int PRW = MW + VEC_WIDTH;
  localparam int SW  = PRW + 2;

  localparam logic [QW-1:0]        QUAT_ONE_RST = {1'b0, {QUAT_FRAC_BITS{1'b1}}};
  localparam logic signed [RW-1:0] ONE_RAW = RW'(1) <<< (2 * QUAT_FRAC_BITS);
  localparam logic signed [MW-1:0] ONE_Q   = MW'(1) <<< QUAT_FRAC_BITS;
  localparam logic signed [VEC_WIDTH-1:0] SAT_HI = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [VEC_WIDTH-1:0] SAT_LO = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [QW-1:0] quat_w;
  logic [QW-1:0] quat_x;
  logic [QW-1:0] quat_y;
  logic [QW-1:0] quat_z;
  logic [1:0]    matrix_source;
  logic          cfg_write;
  logic [2:0]    cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_w        <= QUAT_ONE_RST;
      quat_x        <= '0;
      quat_y        <= '0;
      quat_z        <= '0;
      matrix_source <= SRC_IDENTITY;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_QUAT_W:        quat_w        <= pwdata[QW-1:0];
        REG_QUAT_X:        quat_x        <= pwdata[QW-1:0];
        REG_QUAT_Y:        quat_y        <= pwdata[QW-1:0];
        REG_QUAT_Z:        quat_z        <= pwdata[QW-1:0];
        REG_MATRIX_SOURCE: matrix_source <= pwdata[1:0];
        default: ;  // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_QUAT_W:        prdata = APB_DATA_W'(quat_w);
      REG_QUAT_X:        prdata = APB_DATA_W'(quat_x);
      REG_QUAT_Y:        prdata = APB_DATA_W'(quat_y);
      REG_QUAT_Z:        prdata = APB_DATA_W'(quat_z);
      REG_MATRIX_SOURCE: prdata = APB_DATA_W'(matrix_source);
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Matrix build, stage A: the nine quaternion products (w*w is not needed
  // for a matrix that assumes a unit quaternion).
  // --------------------------------------------------------------------------
  logic signed [QW-1:0] qw, qx, qy, qz;
  logic signed [PW-1:0] pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
  logic [1:0]           src_a;

  assign qw = $signed(quat_w);
  assign qx = $signed(quat_x);
  assign qy = $signed(quat_y);
  assign qz = $signed(quat_z);

  always_ff @(posedge clk) begin
    pxx   <= qx * qx;
    pyy   <= qy * qy;
    pzz   <= qz * qz;
    pxy   <= qx * qy;
    pxz   <= qx * qz;
    pyz   <= qy * qz;
    pwx   <= qw * qx;
    pwy   <= qw * qy;
    pwz   <= qw * qz;
    src_a <= matrix_source;
  end

  // --------------------------------------------------------------------------
  // Matrix build, stage B: exact entries in Q4.2F, floored down to Q4.F.
  // Object-to-inertial flips the sign of every w term.
  // --------------------------------------------------------------------------
  logic signed [MW-1:0] mat      [3][3];
  logic signed [MW-1:0] mat_next [3][3];

  always_comb begin
    logic signed [RW-1:0] raw [3][3];
    logic signed [RW-1:0] ewx, ewy, ewz;
    logic signed [RW-1:0] shr;
    logic                 use_quat;

    use_quat = (src_a == SRC_I2O) || (src_a == SRC_O2I);
    ewx = (src_a == SRC_O2I) ? -RW'(pwx) : RW'(pwx);
    ewy = (src_a == SRC_O2I) ? -RW'(pwy) : RW'(pwy);
    ewz = (src_a == SRC_O2I) ? -RW'(pwz) : RW'(pwz);

    raw[0][0] = ONE_RAW - ((RW'(pyy) + RW'(pzz)) <<< 1);
    raw[0][1] = (RW'(pxy) + ewz) <<< 1;
    raw[0][2] = (RW'(pxz) - ewy) <<< 1;
    raw[1][0] = (RW'(pxy) - ewz) <<< 1;
    raw[1][1] = ONE_RAW - ((RW'(pxx) + RW'(pzz)) <<< 1);
    raw[1][2] = (RW'(pyz) + ewx) <<< 1;
    raw[2][0] = (RW'(pxz) + ewy) <<< 1;
    raw[2][1] = (RW'(pyz) - ewx) <<< 1;
    raw[2][2] = ONE_RAW - ((RW'(pxx) + RW'(pyy)) <<< 1);

    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        shr = raw[i][j] >>> QUAT_FRAC_BITS;
        if (use_quat) begin
          mat_next[i][j] = shr[MW-1:0];
        end else begin
          mat_next[i][j] = (i == j) ? ONE_Q : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    mat <= mat_next;
  end

  // --------------------------------------------------------------------------
  // Vector pipeline. One enable moves every stage; it is low only while a
  // finished result waits at a stalled output.
  // --------------------------------------------------------------------------
  logic adv;
  logic accept;

  assign adv       = !res_valid || !res_stall;
  assign vec_stall = !adv;
  assign accept    = vec_valid && adv;

  logic                        val1, val2, val3, val4;
  logic signed [VEC_WIDTH-1:0] vec1 [3];
  logic signed [VEC_WIDTH-1:0] vec2 [3];
  logic                        dir1, dir2;
  logic signed [PRW-1:0]       prod      [3][3];
  logic signed [PRW-1:0]       prod_next [3][3];
  logic signed [SW-1:0]        row_sum   [3];
  logic signed [VEC_WIDTH-1:0] res_next  [3];
  logic                        sat_next;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      val1      <= 1'b0;
      val2      <= 1'b0;
      val3      <= 1'b0;
      val4      <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      val1      <= accept;
      val2      <= val1;
      val3      <= val2;
      val4      <= val3;
      res_valid <= val4;
    end
  end

  // Entry by component products; direction picks the matrix or its transpose.
  always_comb begin
    logic signed [MW-1:0] coef;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef            = dir2 ? mat[i][j] : mat[j][i];
        prod_next[i][j] = coef * vec2[j];
      end
    end
  end

  // Floor each row sum, then clamp to the output range.
  always_comb begin
    logic signed [SW-1:0] shr;
    logic                 ovf;
    sat_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      shr = row_sum[i] >>> QUAT_FRAC_BITS;
      ovf = !((&shr[SW-1:VEC_WIDTH-1]) || !(|shr[SW-1:VEC_WIDTH-1]));
      if (ovf) begin
        res_next[i] = shr[SW-1] ? SAT_LO : SAT_HI;
        sat_next    = 1'b1;
      end else begin
        res_next[i] = shr[VEC_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: capture the beat
      vec1[0] <= vec_x;
      vec1[1] <= vec_y;
      vec1[2] <= vec_z;
      dir1    <= direction;
      // stage 2: wait for the matrix to follow a fresh register write
      vec2    <= vec1;
      dir2    <= dir1;
      // stage 3: nine products
      prod    <= prod_next;
      // stage 4: row sums
      for (int i = 0; i < 3; i++) begin
        row_sum[i] <= SW'(prod[i][0]) + SW'(prod[i][1]) + SW'(prod[i][2]);
      end
      // stage 5: output register
      out_x     <= res_next[0];
      out_y     <= res_next[1];
      out_z     <= res_next[2];
      saturated <= sat_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `QVR_ASSERT(a_identity_matrix, clk, rst,
    ($past(matrix_source, 2) == SRC_IDENTITY) |->
      (mat[0][0] == ONE_Q && mat[1][1] == ONE_Q && mat[2][2] == ONE_Q &&
       mat[0][1] == '0 && mat[1][2] == '0 && mat[2][0] == '0),
    "identity source did not give the identity matrix")

  `QVR_ASSERT(a_empty_pipe, clk, rst,
    (!val1 && !val2 && !val3 && !val4 && !res_valid) |=> !res_valid,
    "result appeared from an empty pipeline")

  `QVR_ASSERT(a_sat_on_rail, clk, rst,
    (res_valid && saturated) |->
      (out_x == SAT_HI || out_x == SAT_LO || out_y == SAT_HI ||
       out_y == SAT_LO || out_z == SAT_HI || out_z == SAT_LO),
    "saturated flag set with no component at a rail")

endmodule

`default_nettype wire

// ===== verif/quaternion_vector_rotator_tb.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotator_tb
// Self-checking bench for the quaternion vector rotator.
// ----------------------------------------------------------------------------
// Programs quaternion and matrix source over APB, streams vector beats
// through the rotator and compares every rotated beat against a matrix
// rebuilt from the programmed registers. Runs a short directed set, then
// random segments under varying source idle and sink stall rates.
// ----------------------------------------------------------------------------

typedef logic signed [qvr_pkg::VEC_WIDTH_DEF-1:0]  comp_t;
typedef logic signed [qvr_pkg::QUAT_FRAC_BITS_DEF:0] quat_t;

typedef struct packed {
  comp_t x;
  comp_t y;
  comp_t z;
  logic  sat;
} rotated_t;

class rotation_ledger;
  quat_t      q_w, q_x, q_y, q_z;
  logic [1:0] source;
  rotated_t   pending_rotations[$];
  int         mismatches;

  function new();
    q_w = {1'b0, {qvr_pkg::QUAT_FRAC_BITS_DEF{1'b1}}};
    q_x = '0;
    q_y = '0;
    q_z = '0;
    source = qvr_pkg::SRC_IDENTITY;
    mismatches = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      qvr_pkg::REG_QUAT_W:        q_w = data[qvr_pkg::QUAT_FRAC_BITS_DEF:0];
      qvr_pkg::REG_QUAT_X:        q_x = data[qvr_pkg::QUAT_FRAC_BITS_DEF:0];
      qvr_pkg::REG_QUAT_Y:        q_y = data[qvr_pkg::QUAT_FRAC_BITS_DEF:0];
      qvr_pkg::REG_QUAT_Z:        q_z = data[qvr_pkg::QUAT_FRAC_BITS_DEF:0];
      qvr_pkg::REG_MATRIX_SOURCE: source = data[1:0];
      default: ;
    endcase
  endfunction

  // Rebuild the matrix from the current registers and rotate one vector.
  function rotated_t rotate_by_config(comp_t vx, comp_t vy, comp_t vz, logic fwd);
    longint m[3][3];
    longint v[3];
    longint w, x, y, z, one, s, acc, hi, lo;
    comp_t  o[3];
    rotated_t r;
    w = q_w;
    x = q_x;
    y = q_y;
    z = q_z;
    one = longint'(1) << (2 * qvr_pkg::QUAT_FRAC_BITS_DEF);
    hi = (longint'(1) << (qvr_pkg::VEC_WIDTH_DEF - 1)) - 1;
    lo = -hi - 1;
    if (source == qvr_pkg::SRC_I2O || source == qvr_pkg::SRC_O2I) begin
      // w terms flip sign between the two quaternion forms
      s = (source == qvr_pkg::SRC_I2O) ? 1 : -1;
      m[0][0] = one - 2 * (y * y + z * z);
      m[0][1] = 2 * (x * y + s * w * z);
      m[0][2] = 2 * (x * z - s * w * y);
      m[1][0] = 2 * (x * y - s * w * z);
      m[1][1] = one - 2 * (x * x + z * z);
      m[1][2] = 2 * (y * z + s * w * x);
      m[2][0] = 2 * (x * z + s * w * y);
      m[2][1] = 2 * (y * z - s * w * x);
      m[2][2] = one - 2 * (x * x + y * y);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          m[i][j] = m[i][j] >>> qvr_pkg::QUAT_FRAC_BITS_DEF;
    end else begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          m[i][j] = (i == j) ? (longint'(1) << qvr_pkg::QUAT_FRAC_BITS_DEF) : 0;
    end
    v[0] = vx;
    v[1] = vy;
    v[2] = vz;
    r.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++)
        acc += (fwd ? m[i][j] : m[j][i]) * v[j];
      acc = acc >>> qvr_pkg::QUAT_FRAC_BITS_DEF;
      if (acc > hi) begin
        acc = hi;
        r.sat = 1'b1;
      end
      if (acc < lo) begin
        acc = lo;
        r.sat = 1'b1;
      end
      o[i] = acc[qvr_pkg::VEC_WIDTH_DEF-1:0];
    end
    r.x = o[0];
    r.y = o[1];
    r.z = o[2];
    return r;
  endfunction

  function void note_vector(comp_t vx, comp_t vy, comp_t vz, logic fwd);
    pending_rotations.push_back(rotate_by_config(vx, vy, vz, fwd));
  endfunction

  function void check_field(string name, comp_t want, comp_t got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_rotated(comp_t ox, comp_t oy, comp_t oz, logic sat);
    rotated_t e;
    if (pending_rotations.size() == 0) begin
      $error("rotated beat with no vector in flight: %0d %0d %0d", ox, oy, oz);
      mismatches++;
      return;
    end
    e = pending_rotations.pop_front();
    check_field("out_x", e.x, ox);
    check_field("out_y", e.y, oy);
    check_field("out_z", e.z, oz);
    check_field("saturated", e.sat, sat);
  endfunction
endclass

module quaternion_vector_rotator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qvr_pkg::*;

  localparam logic [1:0] SRC_SPARE = 2'd3;  // unused code, must act as identity
  localparam logic       DIR_I2O   = 1'b0;  // transpose
  localparam logic       DIR_O2I   = 1'b1;  // matrix as built
  localparam comp_t      VEC_MAX   = {1'b0, {VEC_WIDTH_DEF-1{1'b1}}};
  localparam comp_t      VEC_MIN   = {1'b1, {VEC_WIDTH_DEF-1{1'b0}}};
  localparam quat_t      Q_MAX     = {1'b0, {QUAT_FRAC_BITS_DEF{1'b1}}};
  localparam quat_t      Q_MIN     = {1'b1, {QUAT_FRAC_BITS_DEF{1'b0}}};
  localparam quat_t      Q_HALF_SQRT2 = 23170;  // cos(45 deg) in Q1.15

  localparam int SEGMENTS      = 5;
  localparam int BEATS_PER_SEG = 92;

  // Idle and stall percentages per random phase: none, source only,
  // sink only, then both.
  int idle_plan[4]  = '{0, 58, 0, 16};
  int stall_plan[4] = '{0, 0, 58, 16};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  vec_valid = 1'b0;
  logic                  vec_stall;
  comp_t                 vec_x = '0;
  comp_t                 vec_y = '0;
  comp_t                 vec_z = '0;
  logic                  direction = 1'b0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  comp_t                 out_x;
  comp_t                 out_y;
  comp_t                 out_z;
  logic                  saturated;

  int send_idle_pct = 0;
  int stall_pct = 0;

  rotation_ledger rotations;

  quaternion_vector_rotator uut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .vec_valid (vec_valid),
    .vec_stall (vec_stall),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .direction (direction),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .saturated (saturated)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  // Sink side: stall at the rate of the current phase, one decision per edge.
  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // Check every rotated beat the sink takes. Input beats are logged by the
  // driver at acceptance, so the log is never behind the pipeline.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      rotations.check_rotated(out_x, out_y, out_z, saturated);
  end

  // One APB write: setup cycle, then access until pready. Leave psel up so
  // writes can go back to back; load_config drops it once at the end.
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rotations.write_reg(idx, data);
  endtask

  // Program all five registers. Upper data bits carry noise that the block
  // must drop. With spare set, also hit the addresses past the last register,
  // which must leave the programmed state alone.
  task automatic load_config(input quat_t w, input quat_t x, input quat_t y,
                             input quat_t z, input logic [1:0] src, input bit spare);
    logic [31:0] noise;
    noise = $urandom;
    apb_write(REG_QUAT_W, {noise[31:16], w});
    apb_write(REG_QUAT_X, {noise[15:0], x});
    apb_write(REG_QUAT_Y, {noise[23:8], y});
    apb_write(REG_QUAT_Z, {noise[31:24], noise[7:0], z});
    apb_write(REG_MATRIX_SOURCE, {noise[29:0], src});
    if (spare)
      for (int k = int'(REG_MATRIX_SOURCE) + 1; k < 8; k++)
        apb_write(3'(k), $urandom);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offer one vector beat after a random idle gap; hold it until taken.
  task automatic send_vector(input comp_t vx, input comp_t vy, input comp_t vz,
                             input logic dir);
    while ($urandom_range(99) < send_idle_pct) begin
      vec_valid <= 1'b0;
      @(posedge clk);
    end
    vec_valid <= 1'b1;
    vec_x <= vx;
    vec_y <= vy;
    vec_z <= vz;
    direction <= dir;
    @(posedge clk);
    while (vec_stall) @(posedge clk);
    rotations.note_vector(vx, vy, vz, dir);
  endtask

  // Stop offering beats and wait for every rotated beat to come back.
  task automatic wait_for_results();
    vec_valid <= 1'b0;
    while (rotations.pending_rotations.size() != 0) @(posedge clk);
  endtask

  // Mix of extremes, full-range and shrunk values so results both clamp
  // and stay in range.
  function automatic comp_t pick_component();
    comp_t c;
    c = comp_t'($urandom);
    case ($urandom_range(7))
      0:       c = $urandom_range(1) ? VEC_MAX : VEC_MIN;
      1, 2, 3: ;
      default: c = c >>> $urandom_range(20, 1);
    endcase
    return c;
  endfunction

  // Mostly parts within +-0.5 so the quaternion norm stays at or below one;
  // the rest full range or the extremes for non-unit behavior.
  function automatic quat_t pick_quat_part();
    quat_t q;
    q = quat_t'($urandom);
    case ($urandom_range(9))
      0:       q = Q_MAX;
      1:       q = Q_MIN;
      2, 3:    ;
      default: q = q >>> 1;
    endcase
    return q;
  endfunction

  initial begin
    rotations = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset state is identity: beats pass through unchanged.
    send_vector(VEC_MAX, VEC_MAX, VEC_MAX, DIR_I2O);
    send_vector(VEC_MIN, VEC_MIN, VEC_MIN, DIR_O2I);
    send_vector('0, '0, '0, DIR_I2O);
    send_vector(-1, 1, -1, DIR_O2I);
    wait_for_results();

    // Quarter turn about z, both directions.
    load_config(Q_HALF_SQRT2, '0, '0, Q_HALF_SQRT2, SRC_I2O, 1'b0);
    send_vector(1 << 20, '0, '0, DIR_I2O);
    send_vector(1 << 20, '0, '0, DIR_O2I);
    send_vector(VEC_MAX, VEC_MIN, -12345, DIR_I2O);
    wait_for_results();

    // Same turn as object-to-inertial; stray writes past the map must not land.
    load_config(Q_HALF_SQRT2, '0, '0, Q_HALF_SQRT2, SRC_O2I, 1'b1);
    send_vector(1 << 20, 1 << 19, -1, DIR_I2O);
    send_vector(VEC_MIN, VEC_MAX, '0, DIR_O2I);
    wait_for_results();

    // Non-unit quaternion at the negative extreme: entries leave Q2.30 range.
    load_config(Q_MIN, Q_MIN, Q_MIN, Q_MIN, SRC_I2O, 1'b0);
    send_vector(VEC_MAX, VEC_MAX, VEC_MAX, DIR_I2O);
    send_vector(VEC_MIN, VEC_MIN, VEC_MIN, DIR_O2I);
    send_vector(VEC_MAX, VEC_MIN, VEC_MAX, DIR_O2I);
    send_vector(1, -1, '0, DIR_I2O);
    wait_for_results();

    load_config(Q_MAX, Q_MAX, Q_MAX, Q_MAX, SRC_O2I, 1'b0);
    send_vector(VEC_MAX, '0, VEC_MIN, DIR_I2O);
    send_vector(-1, -1, -1, DIR_O2I);
    wait_for_results();

    // Spare source code falls back to identity whatever the quaternion.
    load_config(Q_MIN, Q_MAX, Q_MIN, Q_MAX, SRC_SPARE, 1'b0);
    send_vector(VEC_MAX, VEC_MIN, 77, DIR_I2O);
    send_vector(VEC_MIN, VEC_MAX, -77, DIR_O2I);
    wait_for_results();

    // Random segments; reprogram only once the pipeline is empty.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_plan[phase];
      stall_pct = stall_plan[phase];
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        wait_for_results();
        load_config(pick_quat_part(), pick_quat_part(), pick_quat_part(),
                    pick_quat_part(), 2'($urandom_range(3)), $urandom_range(3) == 0);
        repeat (BEATS_PER_SEG)
          send_vector(pick_component(), pick_component(), pick_component(),
                      logic'($urandom_range(1)));
      end
    end

    wait_for_results();
    // Let any stray beat surface past the pipeline depth.
    repeat (12) @(posedge clk);
    if (rotations.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog: a time limit far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
